// File: design/nplc_pkg.sv
// shared types, constants and the l1 distance function for the nearest palette color block
// no dependencies
package nplc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int INDEX_SPAN          = 256;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [9:0] NO_BEST = 10'd1000;

  typedef logic [7:0] chan_t;
  typedef logic [9:0] dist_t;

  typedef struct packed {
    logic  mode;
    chan_t slot;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t best_index;
    dist_t best_distance;
  } item_t;

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    chan_t res;
    res = (a > b) ? (a - b) : (b - a);
    return res;
  endfunction

  function automatic dist_t l1_dist(chan_t r0, chan_t g0, chan_t b0,
                                    chan_t r1, chan_t g1, chan_t b1);
    dist_t sum;
    sum = {2'b00, abs_diff(r0, r1)} + {2'b00, abs_diff(g0, g1)} + {2'b00, abs_diff(b0, b1)};
    return sum;
  endfunction

endpackage

// File: design/nplc_cell.sv
// one pipeline cell: holds one palette entry and compares the passing pixel against it
// depends on nplc_pkg
module nplc_cell #(
  parameter int ENTRY_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  nplc_pkg::item_t in_item,
  output logic          out_valid,
  output nplc_pkg::item_t out_item
);
  import nplc_pkg::*;

  localparam chan_t IDX = 8'(ENTRY_IDX);

  chan_t ent_red_r, ent_green_r, ent_blue_r;
  logic  out_valid_r;
  item_t out_item_r;
  item_t out_item_nxt;
  dist_t cand_dist;
  logic  wr_en;

  assign wr_en = adv && in_valid && (in_item.mode == MODE_LOAD) && (in_item.slot == IDX);

  always_comb begin
    cand_dist = l1_dist(in_item.red, in_item.green, in_item.blue,
                        ent_red_r, ent_green_r, ent_blue_r);
    out_item_nxt = in_item;
    if ((in_item.mode == MODE_PIXEL) && (cand_dist < in_item.best_distance)) begin
      out_item_nxt.best_distance = cand_dist;
      out_item_nxt.best_index    = IDX;
    end
  end

  // palette entry, black after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_red_r   <= '0;
      ent_green_r <= '0;
      ent_blue_r  <= '0;
    end else if (wr_en) begin
      ent_red_r   <= in_item.red;
      ent_green_r <= in_item.green;
      ent_blue_r  <= in_item.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/nearest_palette_color_l1.sv
// top level of the nearest palette color block (manhattan distance)
// depends on nplc_pkg and nplc_cell
//
//   channel | ports              | tdata                                   | tuser
//   input   | in_tvalid/in_tready | entry_index, red, green, blue (32 bits) | mode
//   result  | out_tvalid/tready   | best_index, best_distance (24 bits)     | -
//
// one transaction enters per cycle while in_tready is high; a pixel passes the input register,
// then the chain of cells, one palette entry per cell, then the output register
// load transactions travel the same chain and write their entry as they pass its cell
// reset clears the palette to black and empties the chain at once
// the whole chain holds while a result waits in the output register
module nearest_palette_color_l1 #(
  parameter int PALETTE_ENTRIES = nplc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // best_index, best_distance, zero fill
);
  import nplc_pkg::*;

  localparam int NUM = (PALETTE_ENTRIES > INDEX_SPAN) ? INDEX_SPAN : PALETTE_ENTRIES;

  logic  adv;
  logic  s_valid [0:NUM];
  item_t s_item  [0:NUM];
  logic  s0_valid_r;
  item_t s0_item_r;
  item_t s0_item_nxt;
  logic  out_valid_r;
  chan_t out_index_r;
  dist_t out_dist_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    s0_item_nxt.mode          = in_tuser;
    s0_item_nxt.slot          = in_tdata[7:0];
    s0_item_nxt.red           = in_tdata[15:8];
    s0_item_nxt.green         = in_tdata[23:16];
    s0_item_nxt.blue          = in_tdata[31:24];
    s0_item_nxt.best_index    = '0;
    s0_item_nxt.best_distance = NO_BEST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item_r <= s0_item_nxt;
    end
  end

  assign s_valid[0] = s0_valid_r;
  assign s_item[0]  = s0_item_r;

  for (genvar j = 0; j < NUM; j++) begin : g_cell
    nplc_cell #(
      .ENTRY_IDX(j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (s_valid[j]),
      .in_item   (s_item[j]),
      .out_valid (s_valid[j+1]),
      .out_item  (s_item[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_valid[NUM] && (s_item[NUM].mode == MODE_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r <= s_item[NUM].best_index;
      out_dist_r  <= s_item[NUM].best_distance;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_dist_r, out_index_r};

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:8] <= 10'd765))
    else $error("result distance out of range");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] <= 8'(NUM - 1)))
    else $error("result index beyond searched palette");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s_valid[NUM] && (s_item[NUM].mode == MODE_PIXEL)))
    else $error("result without a pixel leaving the chain");

endmodule
